/* rtl/core/acm_pkg.sv */
package acm_pkg;

  localparam int unsigned DefChannels = 8;
  localparam int unsigned DefSets     = 4;

  localparam logic [5:0] TrimMin    = 6'd0;
  localparam logic [5:0] TrimMax    = 6'd63;
  localparam logic [7:0] FlagDown   = 8'h80;
  localparam logic [7:0] FlagUp     = 8'h40;
  localparam logic [7:0] NeutralOut = 8'd32;
  localparam logic [7:0] IdleOut    = 8'h00;

  typedef enum logic {
    S_IDLE,
    S_CALC
  } acm_state_e;

  typedef struct packed {
    logic [7:0] raw_value;
    logic [2:0] channel;
    logic [1:0] set_index;
    logic       service_active;
    logic       adjust_min;
    logic       dec_request;
    logic       inc_request;
  } acm_in_t;

  typedef struct packed {
    logic [7:0] out_value;
  } acm_out_t;

  // One RAM word holds all four trims of one set and channel.
  typedef struct packed {
    logic [5:0] max_up;
    logic [5:0] max_down;
    logic [5:0] min_up;
    logic [5:0] min_down;
  } trim_word_t;

  localparam trim_word_t TrimReset = '{
    max_up:   TrimMax,
    max_down: TrimMax,
    min_up:   TrimMin,
    min_down: TrimMin
  };

endpackage

/* rtl/core/acm_if.sv */
interface acm_in_if;
  import acm_pkg::*;

  logic    valid;
  logic    ready;
  acm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface acm_out_if;
  import acm_pkg::*;

  logic     valid;
  logic     ready;
  acm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/acm_ram.sv */
module acm_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/analog_channel_trim_mapper.sv */
// Maps one analog byte (6-bit magnitude, down flag in bit 6, up flag in bit 7)
// onto the min..max trim range kept per calibration set and channel, or, in
// service mode, steps the selected trim down and then up (saturating at 0 and
// 63) and returns it with its direction bit. The trim word is read from a
// single RAM with registered read on the accept edge; in the compute state,
// once the output register is free, the scaled result or the adjusted trim
// is computed, written back and loaded into the output register. A new item
// is taken only after the previous write-back, so no access to an entry can
// overlap. The output register lets the next item enter while a result waits.
// Each RAM entry has a valid flop cleared by reset; a never-written entry
// reads as min trims 0 and max trims 63; no clearing pass runs after reset.
module analog_channel_trim_mapper #(
  parameter int unsigned CHANNELS = acm_pkg::DefChannels,
  parameter int unsigned SETS     = acm_pkg::DefSets
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  acm_in_if.sink   in_i,
  acm_out_if.source out_o
);
  import acm_pkg::*;

  localparam int unsigned Depth = SETS * CHANNELS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [4:0]  ChanCount = 5'(CHANNELS);
  localparam logic [2:0]  SetCount  = 3'(SETS);

  acm_state_e state_q, state_d;

  acm_in_t          item_q;
  logic [AddrW-1:0] addr_q;
  logic             hit_q;
  logic [Depth-1:0] entry_valid_q;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_data_q, out_data_d;

  logic             in_fire;
  logic             load_out;
  logic [4:0]       ch_red;
  logic [2:0]       set_red;
  logic [6:0]       addr_full;
  logic [AddrW-1:0] rd_addr;

  trim_word_t       ram_rdata;
  trim_word_t       cur;
  trim_word_t       wr_word;
  logic             ram_we;

  logic       is_down, is_up, has_dir;
  logic [5:0] lo, hi, sel, t_dec, t_inc;
  logic       diff_neg;
  logic [5:0] diff_abs;
  logic [11:0] prod;
  logic [6:0] part_sum;
  logic [5:0] quot;
  logic [5:0] level;
  logic [7:0] dir_flag;
  logic [7:0] result;

  // Fold channel and set into range by repeated subtraction of the count.
  always_comb begin
    ch_red  = {2'b00, in_i.data.channel};
    set_red = {1'b0, in_i.data.set_index};
    for (int i = 0; i < 8; i++) begin
      if (ch_red >= ChanCount) begin
        ch_red = ch_red - ChanCount;
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (set_red >= SetCount) begin
        set_red = set_red - SetCount;
      end
    end
  end

  assign addr_full = 7'(set_red) * 7'(CHANNELS) + 7'(ch_red);
  assign rd_addr   = addr_full[AddrW-1:0];

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  acm_ram #(
    .Width($bits(trim_word_t)),
    .Depth(Depth)
  ) u_trim_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr_q),
    .wdata_i(wr_word),
    .re_i   (in_fire),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // Datapath for the item held in item_q.
  always_comb begin
    cur      = hit_q ? ram_rdata : TrimReset;
    is_down  = item_q.raw_value[6] && !item_q.raw_value[7];
    is_up    = item_q.raw_value[7] && !item_q.raw_value[6];
    has_dir  = is_down || is_up;
    lo       = is_up ? cur.min_up : cur.min_down;
    hi       = is_up ? cur.max_up : cur.max_down;
    dir_flag = is_down ? FlagDown : FlagUp;

    // x / 63 with x = 64a + b: quotient is a, plus one when a + b reaches 63.
    diff_neg = hi < lo;
    diff_abs = diff_neg ? (lo - hi) : (hi - lo);
    prod     = 12'(item_q.raw_value[5:0]) * 12'(diff_abs);
    part_sum = 7'(prod[11:6]) + 7'(prod[5:0]);
    quot     = prod[11:6] + 6'(part_sum >= 7'(TrimMax));
    level    = diff_neg ? (lo - quot) : (lo + quot);

    sel   = item_q.adjust_min ? lo : hi;
    t_dec = (item_q.dec_request && sel != TrimMin) ? sel - 6'd1 : sel;
    t_inc = (item_q.inc_request && t_dec != TrimMax) ? t_dec + 6'd1 : t_dec;

    wr_word = cur;
    case ({is_up, item_q.adjust_min})
      2'b00:   wr_word.max_down = t_inc;
      2'b01:   wr_word.min_down = t_inc;
      2'b10:   wr_word.max_up   = t_inc;
      2'b11:   wr_word.min_up   = t_inc;
      default: wr_word = cur;
    endcase

    if (item_q.service_active) begin
      result = has_dir ? ({2'b00, t_inc} | dir_flag) : IdleOut;
    end else begin
      result = has_dir ? ({2'b00, level} | dir_flag) : NeutralOut;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    load_out    = 1'b0;
    ram_we      = 1'b0;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        // Hold the item until the output register is free.
        if (!out_valid_q || out_o.ready) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          out_data_d  = result;
          ram_we      = item_q.service_active && has_dir;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      entry_valid_q <= '0;
      hit_q         <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        hit_q <= entry_valid_q[rd_addr];
      end
      if (ram_we) begin
        entry_valid_q[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_i.data;
      addr_q <= rd_addr;
    end
    out_data_q <= out_data_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.data.out_value = out_data_q;

`ifndef NO_ASSERTIONS
  a_fire_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_CALC)
    else $error("accepted item did not move to the compute state");

  a_write_only_service: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_CALC && item_q.service_active && load_out)
    else $error("trim write outside a service item");

  a_entry_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> entry_valid_q[$past(addr_q)])
    else $error("written entry not marked valid");

  a_normal_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && !item_q.service_active |-> out_data_d != IdleOut)
    else $error("normal mode produced a zero result");
`endif

endmodule
